@@ hw/rtl/array_list_engine_core_assert.svh @@
// ---------------------------------------------------------------------------
// array_list_engine_core_assert.svh
// Assertion macros shared by the list engine RTL. Empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ALE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("array_list_engine_core: check failed");
// next-cycle implication
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("array_list_engine_core: check failed");
`else
`define ALE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/ale_pkg.sv @@
// ---------------------------------------------------------------------------
// ale_pkg
// Command and status codes, result beat type and reset contents of the list.
// ---------------------------------------------------------------------------
package ale_pkg;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_LOAD    = 3'd1,
		OP_DELETE  = 3'd2,
		OP_SEARCH  = 3'd3,
		OP_INSERT  = 3'd4,
		OP_DISPLAY = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_POS   = 3'd4,
		ST_TOO_MANY  = 3'd5,
		ST_LOAD_OVF  = 3'd6
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  fpos;
		logic [31:0] elem;
		logic        last;
	} ale_rsp_t;

	localparam int INIT_COUNT = 4;
	localparam logic [31:0] INIT_WORDS [INIT_COUNT] = '{32'd10, 32'd20, 32'd30, 32'd40};

	// contents of a slot that has not been written since reset
	function automatic logic [31:0] init_word(input logic [7:0] idx);
		logic [31:0] w;
		w = '0;
		if (idx < 8'(INIT_COUNT)) begin
			w = INIT_WORDS[idx[1:0]];
		end
		return w;
	endfunction

endpackage

@@ hw/rtl/ale_in_if.sv @@
// ---------------------------------------------------------------------------
// ale_in_if
// Command channel: one beat carries one command.
// ---------------------------------------------------------------------------
interface ale_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [31:0] value;
	logic [7:0]         position;
	logic [7:0]         count;

	modport source (output valid, output opcode, output value, output position,
		output count, input ready);
	modport sink (input valid, input opcode, input value, input position,
		input count, output ready);
endinterface

@@ hw/rtl/ale_out_if.sv @@
// ---------------------------------------------------------------------------
// ale_out_if
// Result channel: one beat carries one result.
// ---------------------------------------------------------------------------
interface ale_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [4:0]         found_position;
	logic signed [31:0] element;
	logic [4:0]         element_count;
	logic               last;

	modport source (output valid, output status, output found_position,
		output element, output element_count, output last, input ready);
	modport sink (input valid, input status, input found_position,
		input element, input element_count, input last, output ready);
endinterface

@@ hw/rtl/ale_store.sv @@
// ---------------------------------------------------------------------------
// ale_store
// List storage: one write port, one registered read port, per-slot valid
// bits so that unwritten slots read as their reset contents.
// ---------------------------------------------------------------------------
module ale_store
	import ale_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
	input  logic [31:0]                            wr_data,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
	output logic [31:0]                            rd_data
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [31:0]         mem_q [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [31:0]         rd_data_q;
	logic                rd_valid_q;
	logic [IW-1:0]       rd_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q  <= mem_q[rd_addr];
		rd_valid_q <= valid_q[rd_addr];
		rd_addr_q  <= rd_addr;
	end

	// fall back to the reset contents until a slot is written
	assign rd_data = rd_valid_q ? rd_data_q : init_word(8'(rd_addr_q));

endmodule

@@ hw/rtl/array_list_engine_core.sv @@
// ---------------------------------------------------------------------------
// array_list_engine_core
// Bounded ordered list of 32-bit words: create/load, insert, delete, search
// and display, run by a sequencer over a one-read, one-write list store.
// ---------------------------------------------------------------------------
// The engine takes one command beat at a time and is not ready again until
// the last result beat of that command has been taken. Search, delete,
// insert and display walk the list through the one read port and one write
// port of the store, one slot per cycle while no result beat is waiting:
// search compares slots in turn until a match or the end; delete then moves
// the later entries down; insert moves entries up, then writes the new
// value; display reads each entry, then holds it as a result beat. Create,
// load and tail insert do their one write, if any, in the start state and go
// straight to the result beat. Slots carry valid bits, so the list holds 10,
// 20, 30, 40 right out of reset with no clearing pass. found_position and
// element_count are the low 5 bits of the true values.
// ---------------------------------------------------------------------------
`include "array_list_engine_core_assert.svh"

module array_list_engine_core
	import ale_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	ale_in_if.sink   cmd,
	ale_out_if.source rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = CW + 1;
	localparam logic [8:0]    CAP9    = 9'(CAPACITY);
	localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
	localparam logic [CW-1:0] RST_CNT = CW'((CAPACITY < INIT_COUNT) ? CAPACITY : INIT_COUNT);

	typedef enum logic [2:0] {
		S_IDLE,   // wait for a command beat
		S_START,  // decode, check, issue first read
		S_SCAN,   // compare one slot per cycle
		S_SHDN,   // move entries down over a deleted slot
		S_SHUP,   // move entries up to open a slot
		S_INSWR,  // write the inserted value
		S_DISP,   // load one display result
		S_RESP    // hold a result beat until taken
	} state_t;

	state_t        state_q;
	logic [2:0]    op_q;
	logic [31:0]   val_q;
	logic [7:0]    pos_q;
	logic [7:0]    cntin_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ld_ptr_q;
	logic [CW-1:0] ld_tgt_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] found_q;
	logic          more_q;
	ale_rsp_t      rsp_q;

	// store port
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [IW-1:0] rd_addr;
	logic [31:0]   rd_data;

	// shared compare/step unit
	logic [XW-1:0] idx_x, cnt_x, idx_nx1, idx_nx2;
	logic [8:0]    pos9, cnt9, cntin9;
	logic [IW-1:0] pos_idx;
	logic          ld_ok, too_many, ins_full, ins_bad, ins_tail;
	logic          match, scan_end, shdn_more, shup_end, is_empty;
	logic [31:0]   cnt_w;

	function automatic ale_rsp_t mk_rsp(input status_t s, input logic [4:0] f);
		ale_rsp_t r;
		r.status = s;
		r.fpos   = f;
		r.elem   = '0;
		r.last   = 1'b1;
		return r;
	endfunction

	always_comb begin
		idx_x     = XW'(idx_q);
		cnt_x     = XW'(cnt_q);
		idx_nx1   = idx_x + XW'(1);
		idx_nx2   = idx_x + XW'(2);
		pos9      = {1'b0, pos_q};
		cnt9      = 9'(cnt_q);
		cntin9    = {1'b0, cntin_q};
		// valid only once the position has passed the range check
		pos_idx   = IW'(pos_q);
		ld_ok     = ld_ptr_q < ld_tgt_q;
		too_many  = cntin9 > CAP9;
		ins_full  = cnt_q == CAP_C;
		ins_bad   = pos9 > cnt9;
		ins_tail  = pos9 == cnt9;
		match     = rd_data == val_q;
		scan_end  = idx_nx1 >= cnt_x;
		shdn_more = idx_nx2 < cnt_x;
		shup_end  = (idx_q - IW'(1)) == pos_idx;
		is_empty  = cnt_q == '0;
	end

	// Read address: during a walk, read one step ahead in the direction of travel,
	// so the registered read data is the entry that the current slot needs.
	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			S_START: begin
				if (op_q == OP_INSERT) begin
					rd_addr = IW'(cnt_q - CW'(1));
				end
			end
			S_SCAN, S_RESP: rd_addr = idx_q + IW'(1);
			S_SHDN:         rd_addr = idx_q + IW'(2);
			S_SHUP:         rd_addr = idx_q - IW'(2);
			S_IDLE, S_INSWR, S_DISP: rd_addr = '0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		unique case (state_q)
			S_START: begin
				if (op_q == OP_LOAD && ld_ok) begin
					wr_en   = 1'b1;
					wr_addr = IW'(ld_ptr_q);
					wr_data = val_q;
				end else if (op_q == OP_INSERT && !ins_full && !ins_bad && ins_tail) begin
					wr_en   = 1'b1;
					wr_addr = pos_idx;
					wr_data = val_q;
				end
			end
			S_SHDN, S_SHUP: wr_en = 1'b1;
			S_INSWR: begin
				wr_en   = 1'b1;
				wr_addr = pos_idx;
				wr_data = val_q;
			end
			S_IDLE, S_SCAN, S_DISP, S_RESP: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= '0;
			val_q    <= '0;
			pos_q    <= '0;
			cntin_q  <= '0;
			cnt_q    <= RST_CNT;
			ld_ptr_q <= '0;
			ld_tgt_q <= '0;
			idx_q    <= '0;
			found_q  <= '0;
			more_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q    <= cmd.opcode;
						val_q   <= cmd.value;
						pos_q   <= cmd.position;
						cntin_q <= cmd.count;
						state_q <= S_START;
					end
				end
				S_START: begin
					more_q <= 1'b0;
					// any defined command but a load closes a pending load phase; a create
					// within capacity opens a new one
					if (op_q != OP_LOAD && op_q <= OP_DISPLAY) begin
						ld_ptr_q <= '0;
						ld_tgt_q <= (op_q == OP_CREATE && !too_many) ? CW'(cntin_q) : '0;
					end
					unique case (op_q)
						OP_LOAD: begin
							if (ld_ok) begin
								ld_ptr_q <= ld_ptr_q + CW'(1);
								rsp_q    <= mk_rsp(ST_OK, '0);
							end else begin
								rsp_q <= mk_rsp(ST_LOAD_OVF, '0);
							end
							state_q <= S_RESP;
						end
						OP_CREATE: begin
							if (too_many) begin
								cnt_q <= '0;
								rsp_q <= mk_rsp(ST_TOO_MANY, '0);
							end else begin
								cnt_q <= CW'(cntin_q);
								rsp_q <= mk_rsp(ST_OK, '0);
							end
							state_q <= S_RESP;
						end
						OP_DELETE, OP_SEARCH: begin
							if (is_empty) begin
								rsp_q   <= mk_rsp(ST_EMPTY, '0);
								state_q <= S_RESP;
							end else begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						OP_INSERT: begin
							priority if (ins_full) begin
								rsp_q   <= mk_rsp(ST_FULL, '0);
								state_q <= S_RESP;
							end else if (ins_bad) begin
								rsp_q   <= mk_rsp(ST_BAD_POS, '0);
								state_q <= S_RESP;
							end else if (ins_tail) begin
								cnt_q   <= cnt_q + CW'(1);
								rsp_q   <= mk_rsp(ST_OK, '0);
								state_q <= S_RESP;
							end else begin
								idx_q   <= IW'(cnt_q);
								state_q <= S_SHUP;
							end
						end
						OP_DISPLAY: begin
							if (is_empty) begin
								rsp_q   <= mk_rsp(ST_EMPTY, '0);
								state_q <= S_RESP;
							end else begin
								idx_q   <= '0;
								state_q <= S_DISP;
							end
						end
						default: state_q <= S_IDLE;  // unused codes: drop silently
					endcase
				end
				S_SCAN: begin
					priority if (match) begin
						if (op_q == OP_DELETE && idx_nx1 < cnt_x) begin
							found_q <= idx_q;
							state_q <= S_SHDN;
						end else begin
							if (op_q == OP_DELETE) begin
								cnt_q <= cnt_q - CW'(1);
							end
							rsp_q   <= mk_rsp(ST_OK, 5'(idx_q));
							state_q <= S_RESP;
						end
					end else if (scan_end) begin
						rsp_q   <= mk_rsp(ST_NOT_FOUND, '0);
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_SHDN: begin
					if (shdn_more) begin
						idx_q <= idx_q + IW'(1);
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						rsp_q   <= mk_rsp(ST_OK, 5'(found_q));
						state_q <= S_RESP;
					end
				end
				S_SHUP: begin
					if (shup_end) begin
						state_q <= S_INSWR;
					end else begin
						idx_q <= idx_q - IW'(1);
					end
				end
				S_INSWR: begin
					cnt_q   <= cnt_q + CW'(1);
					rsp_q   <= mk_rsp(ST_OK, '0);
					state_q <= S_RESP;
				end
				S_DISP: begin
					rsp_q.status <= ST_OK;
					rsp_q.fpos   <= '0;
					rsp_q.elem   <= rd_data;
					rsp_q.last   <= scan_end;
					more_q       <= !scan_end;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (rsp.ready) begin
						if (more_q) begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_DISP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

	ale_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// take a command only when fully idle; present results from registers
	assign cmd.ready = state_q == S_IDLE;

	assign cnt_w              = 32'(cnt_q);
	assign rsp.valid          = state_q == S_RESP;
	assign rsp.status         = rsp_q.status;
	assign rsp.found_position = rsp_q.fpos;
	assign rsp.element        = rsp_q.elem;
	assign rsp.element_count  = cnt_w[4:0];
	assign rsp.last           = rsp_q.last;

	`ALE_ASSERT_SAME(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CAP_C)
	`ALE_ASSERT_SAME(a_ld_ptr, clk, arst_n, 1'b1, ld_ptr_q <= ld_tgt_q)
	`ALE_ASSERT_SAME(a_wr_busy, clk, arst_n, wr_en, !cmd.ready && !rsp.valid)
	`ALE_ASSERT_NEXT(a_accept_start, clk, arst_n, cmd.valid && cmd.ready, state_q == S_START)
	`ALE_ASSERT_NEXT(a_last_idle, clk, arst_n, rsp.valid && rsp.ready && rsp.last, cmd.ready)

endmodule
